FILE: src/srfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the sensor response
// frame checker. No dependencies.
package srfc_pkg;

    localparam logic [15:0] CRC_START       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_READ       = 8'h03;
    localparam logic [15:0] SIGN_BIT        = 16'h8000;
    localparam logic [15:0] MAG_MASK        = 16'h7FFF;
    localparam logic [3:0]  MAX_PAYLOAD     = 4'd10;
    localparam logic [3:0]  POS_IDLE        = 4'd15;
    localparam logic [3:0]  LEN_RESET       = 4'd4;
    localparam logic [3:0]  LEN_VALUES      = 4'd4;
    localparam int          SRFC_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_CRC_BAD    = 2'd1,
        ST_HEADER_BAD = 2'd2
    } t_status;

    // What the back end does with one queued word
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CRC_LO = 2'd1,
        KIND_CRC_HI = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        t_kind      kind;
        logic [3:0] pos;
        logic [3:0] len;
        logic       start;
    } t_entry;

    // Reflected CRC-16, one byte, eight shift steps
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: src/srfc_if.sv
// Handshake channels of the sensor response frame checker: input word,
// result word and configuration write. No dependencies.
interface srfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;
    modport source(output valid, rx_byte, frame_start, input ready);
    modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface srfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] humidity_tenths;
    logic signed [15:0] temperature_tenths;
    modport source(output valid, status, humidity_tenths, temperature_tenths, input ready);
    modport sink(input valid, status, humidity_tenths, temperature_tenths, output ready);
endinterface

interface srfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] payload_length;
    modport source(output valid, payload_length, input ready);
    modport sink(input valid, payload_length, output ready);
endinterface

FILE: src/srfc_front.sv
// Front end: tracks the byte position and tags each word for the back end.
// Depends on srfc_pkg.
module srfc_front
    import srfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  logic [3:0] i_payload_length,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_entry     o_push_entry
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [3:0] len;
    logic [3:0] pos_eff;
    logic       drop;
    t_kind      kind;

    always_comb begin
        len     = (i_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_length;
        pos_eff = i_frame_start ? 4'd0 : r_pos;
        drop    = (pos_eff == POS_IDLE);
        if (pos_eff < len + 4'd2) begin
            kind  = KIND_DATA;
            n_pos = pos_eff + 4'd1;
        end else if (pos_eff == len + 4'd2) begin
            kind  = KIND_CRC_LO;
            n_pos = pos_eff + 4'd1;
        end else begin
            kind  = KIND_CRC_HI;
            n_pos = POS_IDLE;
        end
        if (drop) begin
            n_pos = POS_IDLE;
        end
    end

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid && !drop;
    assign o_push_entry = '{rx_byte: i_rx_byte, kind: kind, pos: pos_eff, len: len,
                            start: i_frame_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else if (i_valid && o_ready) begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: src/srfc_queue.sv
// Short word queue between front and back ends.
// Depends on srfc_pkg.
module srfc_queue
    import srfc_pkg::*;
#(
    parameter int DEPTH = SRFC_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_entry,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/srfc_back.sv
// Back end: runs the CRC, header checks and payload capture, and holds the
// result word. Depends on srfc_pkg.
module srfc_back
    import srfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_entry      i_pop_entry,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_humidity_tenths,
    output logic signed [15:0] o_temperature_tenths
);

    logic [15:0] r_crc;
    logic        r_hdr_bad;
    logic [7:0]  r_crc_lo;
    logic [15:0] r_hum;
    logic [15:0] r_tmp;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_hum;
    logic [15:0] r_out_tmp;

    logic [15:0] n_crc;
    logic        n_hdr_bad;
    logic [7:0]  n_crc_lo;
    logic [15:0] n_hum;
    logic [15:0] n_tmp;

    logic [15:0] base_crc;
    logic        base_hdr_bad;
    logic [7:0]  base_crc_lo;
    logic [15:0] base_hum;
    logic [15:0] base_tmp;
    logic        pop;
    logic [15:0] rx_crc;
    t_status     status;
    logic [15:0] tmp_val;

    always_comb begin
        base_crc     = i_pop_entry.start ? CRC_START : r_crc;
        base_hdr_bad = i_pop_entry.start ? 1'b0 : r_hdr_bad;
        base_crc_lo  = i_pop_entry.start ? 8'h00 : r_crc_lo;
        base_hum     = i_pop_entry.start ? 16'h0000 : r_hum;
        base_tmp     = i_pop_entry.start ? 16'h0000 : r_tmp;
        rx_crc       = {i_pop_entry.rx_byte, base_crc_lo};
        if (rx_crc != base_crc) begin
            status = ST_CRC_BAD;
        end else if (base_hdr_bad) begin
            status = ST_HEADER_BAD;
        end else begin
            status = ST_GOOD;
        end
        // Sign-magnitude to two's complement; negative zero maps to zero
        tmp_val = base_tmp[15] ? (16'h0000 - (base_tmp & MAG_MASK)) : base_tmp;

        n_crc     = base_crc;
        n_hdr_bad = base_hdr_bad;
        n_crc_lo  = base_crc_lo;
        n_hum     = base_hum;
        n_tmp     = base_tmp;
        case (i_pop_entry.kind)
            KIND_DATA: begin
                n_crc = crc_update(base_crc, i_pop_entry.rx_byte);
                if (i_pop_entry.pos == 4'd0 && i_pop_entry.rx_byte != FUNC_READ) begin
                    n_hdr_bad = 1'b1;
                end
                if (i_pop_entry.pos == 4'd1 &&
                    i_pop_entry.rx_byte != {4'h0, i_pop_entry.len}) begin
                    n_hdr_bad = 1'b1;
                end
                case (i_pop_entry.pos)
                    4'd2:    n_hum = {i_pop_entry.rx_byte, base_hum[7:0]};
                    4'd3:    n_hum = {base_hum[15:8], i_pop_entry.rx_byte};
                    4'd4:    n_tmp = {i_pop_entry.rx_byte, base_tmp[7:0]};
                    4'd5:    n_tmp = {base_tmp[15:8], i_pop_entry.rx_byte};
                    default: ;
                endcase
            end
            KIND_CRC_LO: begin
                n_crc_lo = i_pop_entry.rx_byte;
            end
            default: ;
        endcase
    end

    // Stall the final word only while an unread result blocks the output
    assign o_pop_ready = (i_pop_entry.kind != KIND_CRC_HI) || !r_out_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_START;
            r_hdr_bad <= 1'b0;
            r_crc_lo  <= 8'h00;
            r_hum     <= 16'h0000;
            r_tmp     <= 16'h0000;
        end else if (pop) begin
            r_crc     <= n_crc;
            r_hdr_bad <= n_hdr_bad;
            r_crc_lo  <= n_crc_lo;
            r_hum     <= n_hum;
            r_tmp     <= n_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_pop_entry.kind == KIND_CRC_HI) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_entry.kind == KIND_CRC_HI) begin
            r_out_status <= status;
            if (status == ST_GOOD && i_pop_entry.len >= LEN_VALUES) begin
                r_out_hum <= base_hum;
                r_out_tmp <= tmp_val;
            end else begin
                r_out_hum <= 16'h0000;
                r_out_tmp <= 16'h0000;
            end
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_humidity_tenths    = r_out_hum;
    assign o_temperature_tenths = $signed(r_out_tmp);

endmodule

FILE: src/sensor_response_frame_checker.sv
// Sensor response frame checker, top level. Uses srfc_pkg, srfc_if,
// srfc_front, srfc_queue and srfc_back.
// Throughput: one word per cycle; the input stalls only when the queue fills.
// The result valid is registered: the frame's CRC high word passes through the queue,
// then sets the back end's result register, which drives the result valid.
// Reset: synchronous, active low; clears position, CRC, queue, result valid,
// and sets the payload length to 4.
module sensor_response_frame_checker
    import srfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = SRFC_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srfc_in_if.sink    i_in,
    srfc_out_if.source o_out,
    srfc_cfg_if.sink   i_cfg
);

    // Payload length register; the user must write it only while the checker is idle (not enforced here)
    logic [3:0] r_payload_length;

    // Front to queue, queue to back
    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_payload_length <= i_cfg.payload_length;
        end
    end

    // Classify each word by frame position; drop words after a frame ends
    srfc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .o_ready          (i_in.ready),
        .i_rx_byte        (i_in.rx_byte),
        .i_frame_start    (i_in.frame_start),
        .i_payload_length (r_payload_length),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_entry     (push_entry)
    );

    // Decouple the front from a back end stalled on its result register
    srfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    // Advance the CRC and checks, emit one result per finished frame
    srfc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_pop_valid          (pop_valid),
        .o_pop_ready          (pop_ready),
        .i_pop_entry          (pop_entry),
        .o_valid              (o_out.valid),
        .i_ready              (o_out.ready),
        .o_status             (o_out.status),
        .o_humidity_tenths    (o_out.humidity_tenths),
        .o_temperature_tenths (o_out.temperature_tenths)
    );

endmodule

FILE: bench/sensor_response_frame_checker_test.sv
// Testbench for sensor_response_frame_checker: drives response frames word by word
// and checks every reading against a predictor kept inside the bench.
// Depends on srfc_pkg, the srfc_*_if interfaces and the checker's top level.
module sensor_response_frame_checker_test;
    import srfc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 8;     // lets the queue and the result register empty, with margin
    localparam int RANDOM_WORDS  = 750;
    localparam int REPORT_LIMIT  = 10;

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        t_status            status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_reading;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    srfc_in_if  in_if();
    srfc_out_if out_if();
    srfc_cfg_if cfg_if();

    sensor_response_frame_checker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the frame state and the length register
    logic [3:0]  model_len     = LEN_RESET;
    logic [15:0] model_crc     = CRC_START;
    logic [3:0]  model_pos     = 4'd0;
    logic        model_hdr_bad = 1'b0;
    logic [7:0]  model_crc_lo  = 8'h00;
    logic [15:0] model_hum     = 16'h0000;
    logic [15:0] model_temp    = 16'h0000;

    t_reading pending_readings[$];

    logic [3:0] length_setting = LEN_RESET;  // what the stimulus builds frames for
    int  words_framed     = 0;
    int  readings_checked = 0;
    int  mismatches       = 0;
    int  idle_cycles      = 0;
    int  settings_written = 0;
    int  stall_left       = 0;
    bit  send_gaps_on     = 1'b1;
    bit  sink_stalls_on   = 1'b1;

    // Mostly no gap, often a short one, now and then a long one; no gap when busy is off
    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Lean on the edge values so extremes of humidity and temperature show up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte_q quad(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                     logic [7:0] d);
        t_byte_q q;
        q.push_back(a);
        q.push_back(b);
        q.push_back(c);
        q.push_back(d);
        return q;
    endfunction

    function automatic t_byte_q random_payload(int span);
        t_byte_q q;
        for (int i = 0; i < span; i++) begin
            q.push_back(pick_byte());
        end
        return q;
    endfunction

    // Reflected CRC-16, one byte folded in LSB first
    function automatic logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic int clamp_span(logic [3:0] len);
        return (len > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(len);
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // Advance the frame state by one accepted word; queue a reading at the frame's last word
    function automatic void predict_word(logic [7:0] b, logic start);
        int       span;
        int       p;
        t_reading r;
        span = clamp_span(model_len);
        if (start) begin
            model_crc     = CRC_START;
            model_pos     = 4'd0;
            model_hdr_bad = 1'b0;
            model_crc_lo  = 8'h00;
            model_hum     = 16'h0000;
            model_temp    = 16'h0000;
        end
        // idle after a finished frame: drop the word
        if (model_pos == POS_IDLE) begin
            return;
        end
        words_framed++;
        if (int'(model_pos) < span + 2) begin
            model_crc = crc16_fold(model_crc, b);
            if (model_pos == 4'd0 && b != FUNC_READ) begin
                model_hdr_bad = 1'b1;
            end
            if (model_pos == 4'd1 && int'(b) != span) begin
                model_hdr_bad = 1'b1;
            end
            p = int'(model_pos) - 2;
            case (p)
                0: model_hum[15:8]  = b;
                1: model_hum[7:0]   = b;
                2: model_temp[15:8] = b;
                3: model_temp[7:0]  = b;
                default: ;
            endcase
            model_pos = model_pos + 4'd1;
        end else if (int'(model_pos) == span + 2) begin
            model_crc_lo = b;
            model_pos    = model_pos + 4'd1;
        end else begin
            // CRC wins over the header check
            if ({b, model_crc_lo} != model_crc) begin
                r.status = ST_CRC_BAD;
            end else if (model_hdr_bad) begin
                r.status = ST_HEADER_BAD;
            end else begin
                r.status = ST_GOOD;
            end
            r.humidity    = 16'h0000;
            r.temperature = 16'sh0000;
            if (r.status == ST_GOOD && span >= 4) begin
                r.humidity = model_hum;
                // sign-magnitude to two's complement; negative zero lands on 0
                r.temperature = model_temp[15] ? (16'h0000 - {1'b0, model_temp[14:0]})
                                               : model_temp;
            end
            pending_readings.push_back(r);
            model_pos = POS_IDLE;
        end
    endfunction

    // Watch all three channels at each edge: check readings, track the register,
    // predict from accepted words, and count cycles with no traffic.
    always @(posedge i_clk) begin : monitor
        t_reading want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                moved = 1'b1;
                readings_checked++;
                if (pending_readings.size() == 0) begin
                    note_mismatch($sformatf("unexpected reading: status %0d hum %0d temp %0d",
                                            out_if.status, out_if.humidity_tenths,
                                            out_if.temperature_tenths));
                end else begin
                    want = pending_readings.pop_front();
                    if (out_if.status !== want.status ||
                        out_if.humidity_tenths !== want.humidity ||
                        out_if.temperature_tenths !== want.temperature) begin
                        note_mismatch($sformatf({"reading mismatch: expected status %0d hum %0d",
                                                 " temp %0d, got status %0d hum %0d temp %0d"},
                                                want.status, want.humidity, want.temperature,
                                                out_if.status, out_if.humidity_tenths,
                                                out_if.temperature_tenths));
                    end
                end
            end
            if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
                moved     = 1'b1;
                model_len = cfg_if.payload_length;
            end
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
                moved = 1'b1;
                predict_word(in_if.rx_byte, in_if.frame_start);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Receiver: hold ready low for random stretches when stalls are on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap(sink_stalls_on);
        end
    end

    // Present one word and hold it until taken, then maybe drop valid for a gap
    task automatic send_word(logic [7:0] b, logic start);
        int gap;
        in_if.valid       <= 1'b1;
        in_if.rx_byte     <= b;
        in_if.frame_start <= start;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        gap = pick_gap(send_gaps_on);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Build header, payload and CRC; keep < 0 sends the whole frame, else only
    // the first keep words
    task automatic send_frame(logic [7:0] fc, logic [7:0] count, t_byte_q payload,
                              logic [15:0] crc_flip, int keep, bit with_start);
        t_byte_q     words;
        logic [15:0] crc;
        int          n;
        words.push_back(fc);
        words.push_back(count);
        foreach (payload[i]) begin
            words.push_back(payload[i]);
        end
        crc = CRC_START;
        foreach (words[i]) begin
            crc = crc16_fold(crc, words[i]);
        end
        crc = crc ^ crc_flip;
        words.push_back(crc[7:0]);
        words.push_back(crc[15:8]);
        n = (keep < 0 || keep > words.size()) ? words.size() : keep;
        for (int i = 0; i < n; i++) begin
            send_word(words[i], (i == 0) ? with_start : 1'b0);
        end
    endtask

    // Stop sending, wait for every reading, then let the pipeline settle
    task automatic drain_readings();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Call only with the block idle
    task automatic write_length(logic [3:0] len);
        cfg_if.valid          <= 1'b1;
        cfg_if.payload_length <= len;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid   <= 1'b0;
        length_setting  = len;
        settings_written++;
    endtask

    // First frame after reset carries no frame_start; max humidity, negative-zero
    // temperature, then a stray word after the frame that must be dropped
    task automatic test_frame_without_start();
        send_frame(FUNC_READ, 8'd4, quad(8'hFF, 8'hFF, 8'h80, 8'h00), 16'h0000, -1, 1'b0);
        send_word(8'hA5, 1'b0);
    endtask

    // Abandon a frame after three words and restart; most negative temperature
    task automatic test_restart_mid_frame();
        send_frame(FUNC_READ, 8'd4, random_payload(4), 16'h0000, 3, 1'b1);
        send_frame(FUNC_READ, 8'd4, quad(8'h00, 8'h00, 8'hFF, 8'hFF), 16'h0000, -1, 1'b1);
    endtask

    // Empty payload: good frame, CRC error, wrong function code, wrong count
    task automatic test_status_codes();
        t_byte_q none;
        drain_readings();
        write_length(4'd0);
        send_frame(FUNC_READ, 8'd0, none, 16'h0000, -1, 1'b1);
        send_frame(FUNC_READ, 8'd0, none, 16'h0100, -1, 1'b1);
        send_frame(8'h04, 8'd0, none, 16'h0000, -1, 1'b1);
        send_frame(FUNC_READ, 8'd1, none, 16'h0000, -1, 1'b1);
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic random_frame();
        int          span;
        int          kind;
        t_byte_q     pay;
        logic [7:0]  fc;
        logic [7:0]  cnt;
        span = clamp_span(length_setting);
        pay  = random_payload(span);
        fc   = FUNC_READ;
        cnt  = 8'(span);
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            send_frame(fc, cnt, pay, 16'h0000, -1, 1'b1);
        end else if (kind < 73) begin
            send_frame(fc, cnt, pay, 16'($urandom_range(1, 65535)), -1, 1'b1);
        end else if (kind < 80) begin
            // good CRC over a bad header
            if ($urandom_range(0, 1) == 1) begin
                fc = pick_byte();
                if (fc == FUNC_READ) begin
                    fc = ~fc;
                end
            end else begin
                cnt = cnt ^ 8'($urandom_range(1, 255));
            end
            send_frame(fc, cnt, pay, 16'h0000, -1, 1'b1);
        end else if (kind < 87) begin
            send_frame(fc, cnt, pay, 16'h0000, $urandom_range(1, span + 3), 1'b1);
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 12)) begin
                send_word(pick_byte(), ($urandom_range(0, 9) == 0));
            end
        end else begin
            // trailing words after a finished frame are dropped by the block
            send_frame(fc, cnt, pay, 16'h0000, -1, 1'b1);
            repeat ($urandom_range(1, 3)) begin
                send_word(pick_byte(), 1'b0);
            end
        end
    endtask

    // Sweep the length register through its extremes and clamped values, then random
    // settings, each phase with its own idling mix
    task automatic test_random_traffic();
        logic [3:0] sweep[$];
        int         stop_at;
        int         phase_end;
        int         idx;
        logic [3:0] setting;
        sweep   = '{4'd15, 4'd10, 4'd1, 4'd4, 4'd3, 4'd0, 4'd11, 4'd7};
        stop_at = words_framed + RANDOM_WORDS;
        idx     = 0;
        while (words_framed < stop_at) begin
            setting = (idx < sweep.size()) ? sweep[idx] : 4'($urandom_range(0, 15));
            idx++;
            drain_readings();
            write_length(setting);
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            phase_end      = words_framed + $urandom_range(40, 80);
            while (words_framed < phase_end) begin
                random_frame();
                // hold off now and then until every reading is back
                if ($urandom_range(0, 49) == 0) begin
                    drain_readings();
                end
            end
        end
    endtask

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        in_if.valid           = 1'b0;
        in_if.rx_byte         = 8'h00;
        in_if.frame_start     = 1'b0;
        out_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.payload_length = LEN_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_without_start();
        test_restart_mid_frame();
        test_status_codes();
        test_random_traffic();
        drain_readings();

        $display("Covered %0d framed words and %0d readings over %0d length settings",
                 words_framed, readings_checked, settings_written);
        $display("including empty, short, full and clamped payloads, restarts and noise");
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d readings never arrived", mismatches,
                     pending_readings.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/srfc_pkg.sv
src/srfc_if.sv
src/srfc_front.sv
src/srfc_queue.sv
src/srfc_back.sv
src/sensor_response_frame_checker.sv
bench/sensor_response_frame_checker_test.sv
